FILE: rtl/sobel_gradient_direction_macros.svh
// Assertion macros shared by the Sobel gradient blocks.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SOBEL_GRADIENT_DIRECTION_MACROS_SVH
`define SOBEL_GRADIENT_DIRECTION_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SGD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sgd_pkg.sv
// Shared constants, codes and control types of the Sobel gradient block.
// Used by the controller, the datapath and the top level.
package sgd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int CFG_W  = 13;
    localparam int PEND_W = 11;
    localparam int PIX_W  = 24;
    localparam int PIX_BYTE = 8;
    localparam int GRAD_W = 11;
    localparam int MAG_W  = 15;
    localparam int SQRT_STEPS = 15;
    localparam int STEP_W = 4;

    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
    localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_0   = 2'd0;
    localparam logic [1:0] DIR_45  = 2'd1;
    localparam logic [1:0] DIR_90  = 2'd2;
    localparam logic [1:0] DIR_135 = 2'd3;

    typedef struct packed {
        logic accept;
        logic read;
        logic advance;
        logic second;
        logic mul;
        logic sqrt_init;
        logic sqrt_step;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic work;
        logic has_result;
        logic dbl;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: rtl/sobel_gradient_direction.sv
// Sobel gradient, magnitude and direction sector over a raster pixel stream.
// A request with a result steps through read, advance, multiply, root setup, the 15-step
// bit-serial square root and done, where it waits until the held output is taken; then it
// loads the result. A pixel without a result reads and advances, a two-step flush twice;
// an ignored flush stays idle. Reset is asynchronous and active low; it restores the 640x480
// frame size and clears counters, window and output valid; the line stores are not cleared.
module sobel_gradient_direction import sgd_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [PIX_W-1:0]         pixel,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [GRAD_W-1:0] gradient_one,
    output logic signed [GRAD_W-1:0] gradient_two,
    output logic [MAG_W-1:0]         magnitude,
    output logic [1:0]               direction,
    output logic                     end_of_frame
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    sgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sgd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .pixel        (pixel),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gradient_one (gradient_one),
        .gradient_two (gradient_two),
        .magnitude    (magnitude),
        .direction    (direction),
        .end_of_frame (end_of_frame)
    );

endmodule

FILE: rtl/sgd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the line stores.
module sgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/sgd_ctrl.sv
// Controller state machine of the Sobel gradient block.
// Depends on sgd_pkg and the assertion macros header.
`include "sobel_gradient_direction_macros.svh"

module sgd_ctrl import sgd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADV,
        S_MUL,
        S_ROOT0,
        S_ROOT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.work)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                if (status.dbl)
                begin
                    cmd.second = 1'b1;
                    state_next = S_READ;
                end
                else if (status.has_result)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ROOT0;
            end
            S_ROOT0:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

    `SGD_ASSERT_NEXT(a_ready_after_load, cmd.load_out, in_ready_reg, "not ready after result load")
    `SGD_ASSERT_SAME(a_accept_when_ready, cmd.accept, in_ready_reg, "request taken while busy")
    `SGD_ASSERT_NEXT(a_busy, cmd.accept && status.work, !in_ready_reg, "still ready")

endmodule

FILE: rtl/sgd_datapath.sv
// Datapath of the Sobel gradient block: counters, line stores, window, gradients,
// squares, bit-serial square root and the output register. Depends on sgd_pkg, sgd_ram and the macros header.
`include "sobel_gradient_direction_macros.svh"

module sgd_datapath import sgd_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     command,
    input  logic [PIX_W-1:0]         pixel,
    input  ctl_cmd_t                 cmd,
    output dp_status_t               status,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [GRAD_W-1:0] gradient_one,
    output logic signed [GRAD_W-1:0] gradient_two,
    output logic [MAG_W-1:0]         magnitude,
    output logic [1:0]               direction,
    output logic                     end_of_frame
);

    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PEND_W-1:0] pend_reg;

    logic at_start, pix_has, flush_work, dbl, j_lt_w, f_r1;
    logic [PEND_W-1:0] p0, p1, pend_pix;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [FW_W:0]     need, pend_ext, j_val;
    logic [COL_W-1:0]  f_addr;

    logic [COL_W-1:0]    addr_reg, rd_addr;
    logic                r1_reg, dbl_reg, has_reg, phantom_reg, eof_reg, r1_eff, c0;
    logic [PIX_BYTE-1:0] red_reg;
    logic [PIX_BYTE-1:0] upper_q, lower_q;
    logic [PIX_BYTE-1:0] top_v, mid_v, bot_v;

    logic [PIX_BYTE-1:0] win1_reg [3];
    logic [PIX_BYTE-1:0] win2_reg [3];
    logic [PIX_BYTE-1:0] new_col  [3];
    logic [PIX_BYTE-1:0] rcol     [3];
    logic [9:0] bot_s, top_s, lft_s, rgt_s;
    logic signed [GRAD_W-1:0] g1_reg, g2_reg, g1_v, g2_v;

    logic [GRAD_W-1:0] ay11, ax11;
    logic [9:0]  ay, ax, sm;
    logic [10:0] sp;
    logic [19:0] ax2_reg, ay2_reg, sm2_reg;
    logic [21:0] sp2_reg;
    logic gt_reg, zero_reg, same_reg;
    logic [20:0] two_ax2, sum_sq;
    logic [1:0]  dir_v, dir_reg;

    logic [29:0] rad_reg;
    logic [16:0] rem_reg, rem_sh, trial;
    logic [MAG_W-1:0] root_reg;

    logic out_valid_reg;
    logic signed [GRAD_W-1:0] out_g1_reg, out_g2_reg;
    logic [MAG_W-1:0] out_mag_reg;
    logic [1:0] out_dir_reg;
    logic out_eof_reg;

    // Frame size clamped to the supported range.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (width_reg > FW_W'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = FH_W'(1);
        end
        else if (height_reg > FH_W'(MAX_HEIGHT))
        begin
            h_eff = FH_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    always_comb
    begin
        at_start = (row_reg == '0) && (col_reg == '0);
        pix_has  = (col_reg == '0) ? (row_reg >= ROW_W'(2)) : (row_reg != '0);
        p0       = at_start ? '0 : pend_reg;
        p1       = (p0 == PEND_MAX) ? p0 : p0 + PEND_W'(1);
        pend_pix = pix_has ? p1 - PEND_W'(1) : p1;
        col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);
        row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);

        flush_work = (pend_reg != '0) && at_start;
        need       = {1'b0, w_eff} + (FW_W+1)'(1);
        pend_ext   = (FW_W+1)'(pend_reg);
        j_val      = (pend_ext >= need) ? '0 : need - pend_ext;
        j_lt_w     = j_val < {1'b0, w_eff};
        f_addr     = j_lt_w ? j_val[COL_W-1:0] : '0;
        f_r1       = j_lt_w && (h_eff == FH_W'(1));
        dbl        = (h_eff == FH_W'(1)) && (j_val == (FW_W+1)'(1));
    end

    assign status.work       = (command == CMD_PIXEL) || flush_work;
    assign status.has_result = has_reg;
    assign status.dbl        = dbl_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

    // A frame of one row drains its first flush in two steps; the first reads column zero.
    assign rd_addr = dbl_reg ? '0 : addr_reg;
    assign r1_eff  = dbl_reg ? 1'b1 : r1_reg;
    assign c0      = (rd_addr == '0);

    sgd_ram #(.WIDTH(PIX_BYTE), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (cmd.advance && !phantom_reg),
        .waddr (rd_addr),
        .wdata (lower_q),
        .re    (cmd.read),
        .raddr (rd_addr),
        .rdata (upper_q)
    );

    sgd_ram #(.WIDTH(PIX_BYTE), .DEPTH(MAX_WIDTH)) u_lower (
        .clk   (clk),
        .we    (cmd.advance && !phantom_reg),
        .waddr (rd_addr),
        .wdata (red_reg),
        .re    (cmd.read),
        .raddr (rd_addr),
        .rdata (lower_q)
    );

    always_comb
    begin
        top_v = r1_eff ? lower_q : upper_q;
        mid_v = lower_q;
        bot_v = phantom_reg ? lower_q : red_reg;
        new_col[0] = top_v;
        new_col[1] = mid_v;
        new_col[2] = bot_v;
        for (int k = 0; k < 3; k++)
        begin
            rcol[k] = c0 ? win2_reg[k] : new_col[k];
        end
        bot_s = 10'(win1_reg[2]) + {1'b0, win2_reg[2], 1'b0} + 10'(rcol[2]);
        top_s = 10'(win1_reg[0]) + {1'b0, win2_reg[0], 1'b0} + 10'(rcol[0]);
        lft_s = 10'(win1_reg[0]) + {1'b0, win1_reg[1], 1'b0} + 10'(win1_reg[2]);
        rgt_s = 10'(rcol[0]) + {1'b0, rcol[1], 1'b0} + 10'(rcol[2]);
        g1_v  = $signed({1'b0, bot_s}) - $signed({1'b0, top_s});
        g2_v  = $signed({1'b0, lft_s}) - $signed({1'b0, rgt_s});
    end

    always_comb
    begin
        ay11    = g1_reg[GRAD_W-1] ? (~g1_reg + GRAD_W'(1)) : g1_reg;
        ax11    = g2_reg[GRAD_W-1] ? (~g2_reg + GRAD_W'(1)) : g2_reg;
        ay      = ay11[9:0];
        ax      = ax11[9:0];
        sp      = {1'b0, ay} + {1'b0, ax};
        sm      = ay - ax;
        two_ax2 = {ax2_reg, 1'b0};
        sum_sq  = {1'b0, ax2_reg} + {1'b0, ay2_reg};
        if (zero_reg)
        begin
            dir_v = DIR_0;
        end
        else if (sp2_reg < {1'b0, two_ax2})
        begin
            dir_v = DIR_0;
        end
        else if (gt_reg && ({1'b0, sm2_reg} > two_ax2))
        begin
            dir_v = DIR_90;
        end
        else if (same_reg)
        begin
            dir_v = DIR_45;
        end
        else
        begin
            dir_v = DIR_135;
        end
        rem_sh = {rem_reg[14:0], rad_reg[29:28]};
        trial  = {root_reg[14:0], 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            dbl_reg       <= 1'b0;
            has_reg       <= 1'b0;
            phantom_reg   <= 1'b0;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= '0;
                win2_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                begin
                    width_reg <= cfg_data[FW_W-1:0];
                end
                else
                begin
                    height_reg <= cfg_data[FH_W-1:0];
                end
            end
            if (cmd.accept)
            begin
                if (command == CMD_PIXEL)
                begin
                    phantom_reg <= 1'b0;
                    dbl_reg     <= 1'b0;
                    has_reg     <= pix_has;
                    eof_reg     <= 1'b0;
                    pend_reg    <= pend_pix;
                    if (col_inc >= (COL_W+1)'(w_eff))
                    begin
                        col_reg <= '0;
                        row_reg <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        col_reg <= col_inc[COL_W-1:0];
                    end
                end
                else if (flush_work)
                begin
                    phantom_reg <= 1'b1;
                    dbl_reg     <= dbl;
                    has_reg     <= 1'b1;
                    eof_reg     <= (pend_reg == PEND_W'(1));
                    pend_reg    <= pend_reg - PEND_W'(1);
                end
            end
            if (cmd.second)
            begin
                dbl_reg <= 1'b0;
            end
            if (cmd.advance)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win1_reg[k] <= c0 ? new_col[k] : win2_reg[k];
                    win2_reg[k] <= new_col[k];
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            red_reg <= pixel[PIX_W-1:PIX_W-PIX_BYTE];
            if (command == CMD_PIXEL)
            begin
                addr_reg <= col_reg;
                r1_reg   <= (row_reg == ROW_W'(1));
            end
            else
            begin
                addr_reg <= f_addr;
                r1_reg   <= f_r1;
            end
        end
        if (cmd.advance)
        begin
            g1_reg <= g1_v;
            g2_reg <= g2_v;
        end
        if (cmd.mul)
        begin
            ax2_reg  <= ax * ax;
            ay2_reg  <= ay * ay;
            sp2_reg  <= sp * sp;
            sm2_reg  <= sm * sm;
            gt_reg   <= ay > ax;
            zero_reg <= (ax == '0) && (ay == '0);
            same_reg <= (!g1_reg[GRAD_W-1] && g1_reg != '0) ==
                        (!g2_reg[GRAD_W-1] && g2_reg != '0);
        end
        if (cmd.sqrt_init)
        begin
            dir_reg  <= dir_v;
            rad_reg  <= {1'b0, sum_sq, 8'b0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[27:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            out_g1_reg  <= g1_reg;
            out_g2_reg  <= g2_reg;
            out_mag_reg <= root_reg;
            out_dir_reg <= dir_reg;
            out_eof_reg <= eof_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign gradient_one = out_g1_reg;
    assign gradient_two = out_g2_reg;
    assign magnitude    = out_mag_reg;
    assign direction    = out_dir_reg;
    assign end_of_frame = out_eof_reg;

    `SGD_ASSERT_SAME(a_dbl_only_flush, dbl_reg, phantom_reg, "two-step drain outside a flush")
    `SGD_ASSERT_SAME(a_eof_drained, cmd.load_out && eof_reg, pend_reg == '0, "frame end with results left")
    `SGD_ASSERT_SAME(a_load_has_result, cmd.load_out, has_reg, "result loaded for a silent request")

endmodule
